// ===== hw/rtl/mat_pkg.sv =====
`default_nettype none
package mat_pkg;
  localparam int RecEntries = 64;
  localparam int SlotEntries = 32;
  localparam int TierCount = 8;
  localparam int RecW = $clog2(RecEntries);
  localparam int SlotW = $clog2(SlotEntries);
  localparam int TierW = $clog2(TierCount);
  localparam int ResW = RecW + TierW;
  localparam int CntW = $clog2(RecEntries + 1);

  // commands
  localparam logic [2:0] CmdAcquire = 3'd0;
  localparam logic [2:0] CmdRelease = 3'd1;
  localparam logic [2:0] CmdCommit  = 3'd2;
  localparam logic [2:0] CmdDelete  = 3'd3;
  localparam logic [2:0] CmdStop    = 3'd4;

  // status codes
  localparam logic [3:0] StGranted   = 4'd0;
  localparam logic [3:0] StDone      = 4'd1;
  localparam logic [3:0] StStopped   = 4'd2;
  localparam logic [3:0] StInvalid   = 4'd3;
  localparam logic [3:0] StInflight  = 4'd4;
  localparam logic [3:0] StResidency = 4'd5;
  localparam logic [3:0] StCooldown  = 4'd6;
  localparam logic [3:0] StTableFull = 4'd7;
  localparam logic [3:0] StNoOwnSlot = 4'd8;

  // configuration register indexes
  localparam logic [1:0] RegCooldown  = 2'd0;
  localparam logic [1:0] RegResidency = 2'd1;
  localparam logic [1:0] RegMaxRec    = 2'd2;

  // known: one residency-recorded flag per tier, cleared when the record is created
  typedef struct packed {
    logic [31:0] key;
    logic [31:0] inc;
    logic [5:0]  pins;
    logic [31:0] touch;
    logic [47:0] last_off;
    logic [47:0] last_on;
    logic [TierCount-1:0] known;
  } rec_t;

  typedef struct packed {
    logic [31:0] reg_id;
    logic [31:0] blk;
    logic [8:0]  tiers;
    logic [31:0] key;
    logic [31:0] lease;
    logic [31:0] inc;
  } slot_t;

  // true when stamp lies after now or the interval since stamp is shorter than limit
  function automatic logic too_young(input logic [47:0] now, input logic [47:0] stamp,
                                     input logic [31:0] limit);
    logic [47:0] d;
    d = now - stamp;
    return (now < stamp) || (d < {16'd0, limit});
  endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/movement_admission_tracker.sv =====
`default_nettype none
// Movement admission tracker. One command is taken at a time; its result
// leaves through an output register, and the next command is accepted while
// that result waits. Record, slot and residency state sit in synchronous
// memories, so a command walks them one entry per cycle: the slot table scan,
// then the record scan, and each record evicted by trimming costs another
// record scan. Every command runs both scans. Valid bits are flip-flops and
// the per-tier residency flags live in the record entries, so no clearing
// pass follows reset.
module movement_admission_tracker (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // tdata, low bit up: command[2:0], key_tag[31:0], reg_id[31:0],
  // block_number[31:0], block_tier[2:0], source_tier[2:0], dest_tier[2:0],
  // direction, lease_no[31:0], moved, now[47:0]; zero filled to 192 bits
  input  wire logic [191:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // tdata, low bit up: status[3:0], granted_lease[31:0], evicted[6:0]; zero to 48
  output logic [47:0]       out_tdata,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [31:0]  cfg_wdata
);
  localparam int RW = mat_pkg::RecW;
  localparam int SW = mat_pkg::SlotW;
  localparam int CW = mat_pkg::CntW;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_SSCAN = 8'b00000010,
    S_RSCAN = 8'b00000100,
    S_EVAL  = 8'b00001000,
    S_WRITE = 8'b00010000,
    S_TSCAN = 8'b00100000,
    S_DONE  = 8'b01000000,
    S_RDRES = 8'b10000000
  } state_t;

  // configuration
  logic [31:0] cool_r, resid_r;
  logic [6:0]  maxrec_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cool_r <= '0; resid_r <= '0; maxrec_r <= 7'd64;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mat_pkg::RegCooldown:  cool_r <= cfg_wdata;
        mat_pkg::RegResidency: resid_r <= cfg_wdata;
        mat_pkg::RegMaxRec:    maxrec_r <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  // latched command
  typedef struct packed {
    logic [47:0] now; logic moved; logic [31:0] lease; logic dir;
    logic [2:0] dt; logic [2:0] st; logic [2:0] bt;
    logic [31:0] blk; logic [31:0] reg_id; logic [31:0] key; logic [2:0] cmd;
  } cmd_t;
  cmd_t cmd_r;

  // memories
  mat_pkg::rec_t  rec_mem [mat_pkg::RecEntries];
  mat_pkg::slot_t slot_mem [mat_pkg::SlotEntries];
  logic [47:0]    res_mem [mat_pkg::RecEntries * mat_pkg::TierCount];
  logic [mat_pkg::RecEntries-1:0] rvalid_r;
  logic [mat_pkg::SlotEntries-1:0] svalid_r;

  logic [RW-1:0] raddr; logic rwe; mat_pkg::rec_t rwdata, rrd_r;
  logic [SW-1:0] saddr; logic swe; mat_pkg::slot_t swdata, srd_r;
  logic [mat_pkg::ResW-1:0] xaddr; logic xwe; logic [47:0] xrd_r;

  always_ff @(posedge clk) begin
    if (rwe) rec_mem[raddr] <= rwdata;
    rrd_r <= rec_mem[raddr];
  end
  always_ff @(posedge clk) begin
    if (swe) slot_mem[saddr] <= swdata;
    srd_r <= slot_mem[saddr];
  end
  always_ff @(posedge clk) begin
    if (xwe) res_mem[xaddr] <= cmd_r.now;
    xrd_r <= res_mem[xaddr];
  end

  state_t st_r;
  logic [CW-1:0] idx_r, cnt_r;          // scan index and record count
  logic [RW:0]   rhit_r, rfree_r, best_r; // msb = none
  logic [SW:0]   shit_r, sfree_r;
  logic [31:0]   btouch_r, stamp_r, lease_r;
  logic          stop_r;
  logic [3:0]    status_r;
  logic [31:0]   grant_r;
  logic [6:0]    evict_r;
  logic          ovalid_r;
  logic [47:0]   odata_r;
  logic          newrec_r;

  wire [8:0] tiers = {cmd_r.dt, cmd_r.st, cmd_r.bt};
  wire [2:0] src = (cmd_r.st != 3'd0) ? cmd_r.st : cmd_r.bt;
  wire [6:0] limit = (maxrec_r == 7'd0) ? 7'd1 : maxrec_r;
  wire [RW-1:0] ridx = idx_r[RW-1:0];
  wire [SW-1:0] sidx = idx_r[SW-1:0];
  wire [RW-1:0] rh = rhit_r[RW-1:0];
  wire [mat_pkg::TierW-1:0] srct = src[mat_pkg::TierW-1:0];
  wire [mat_pkg::TierW-1:0] cmtt = cmd_r.st[mat_pkg::TierW-1:0];

  assign in_tready = (st_r == S_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tdata = odata_r;

  // previous cycle scan address, matching the registered memory read
  logic [CW-1:0] pidx_r;
  logic          pv_r;
  wire [RW-1:0] prx = pidx_r[RW-1:0];
  wire [SW-1:0] psx = pidx_r[SW-1:0];

  // slot match of a registered read
  wire smatch = svalid_r[psx] && srd_r.reg_id == cmd_r.reg_id &&
                srd_r.blk == cmd_r.blk && srd_r.tiers == tiers;

  // trimming candidate: unpinned and strictly older than the best so far
  wire cand = pv_r && rvalid_r[prx] && rrd_r.pins == '0 &&
              (best_r[RW] || rrd_r.touch < btouch_r);

  // acquire verdict once record, slot and residency reads are back
  wire [47:0] last_mv = cmd_r.dir ? rrd_r.last_on : rrd_r.last_off;
  logic [3:0] acq_st;
  always_comb begin
    priority if (stop_r) acq_st = mat_pkg::StStopped;
    else if (src == 3'd0) acq_st = mat_pkg::StInvalid;
    else if (!shit_r[SW]) acq_st = mat_pkg::StInflight;
    else if (!rhit_r[RW] && ({1'b0, src} < 4'(mat_pkg::TierCount)) &&
             rrd_r.known[srct] && mat_pkg::too_young(cmd_r.now, xrd_r, resid_r))
      acq_st = mat_pkg::StResidency;
    else if (!rhit_r[RW] && last_mv != '0 &&
             mat_pkg::too_young(cmd_r.now, last_mv, cool_r))
      acq_st = mat_pkg::StCooldown;
    else if ((rhit_r[RW] && rfree_r[RW]) || sfree_r[SW])
      acq_st = mat_pkg::StTableFull;
    else acq_st = mat_pkg::StGranted;
  end

  // memory address and write select
  always_comb begin
    raddr = ridx; saddr = sidx; xaddr = {rh, srct};
    rwe = 1'b0; swe = 1'b0; xwe = 1'b0;
    rwdata = rrd_r; swdata = srd_r;
    unique case (st_r)
      S_EVAL, S_RDRES: begin
        raddr = rh;
        saddr = shit_r[SW-1:0];
      end
      S_WRITE: begin
        raddr = rh;
        saddr = (cmd_r.cmd == mat_pkg::CmdAcquire) ? sfree_r[SW-1:0] : shit_r[SW-1:0];
        xaddr = {rh, cmtt};
        rwdata = rrd_r;
        if (newrec_r) begin
          rwdata.key = cmd_r.key; rwdata.pins = '0; rwdata.known = '0;
          rwdata.last_off = '0; rwdata.last_on = '0; rwdata.inc = stamp_r + 32'd1;
        end
        rwe = 1'b1;
        unique case (cmd_r.cmd)
          mat_pkg::CmdAcquire: begin
            rwdata.pins = rwdata.pins + 6'd1;
            rwdata.touch = newrec_r ? stamp_r + 32'd2 : stamp_r + 32'd1;
            swe = 1'b1;
            swdata.reg_id = cmd_r.reg_id; swdata.blk = cmd_r.blk; swdata.tiers = tiers;
            swdata.key = cmd_r.key; swdata.lease = lease_r + 32'd1;
            swdata.inc = newrec_r ? stamp_r + 32'd1 : rrd_r.inc;
          end
          mat_pkg::CmdRelease: begin
            rwe = !rhit_r[RW] && rrd_r.inc == srd_r.inc;
            if (rrd_r.pins != '0) rwdata.pins = rrd_r.pins - 6'd1;
            if (cmd_r.moved && cmd_r.dir) rwdata.last_on = cmd_r.now;
            if (cmd_r.moved && !cmd_r.dir) rwdata.last_off = cmd_r.now;
            rwdata.touch = stamp_r + 32'd1;
          end
          default: begin
            rwdata.touch = newrec_r ? stamp_r + 32'd2 : stamp_r + 32'd1;
            xwe = ({1'b0, cmd_r.st} < 4'(mat_pkg::TierCount));
            if (xwe) rwdata.known[cmtt] = 1'b1;
          end
        endcase
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; ovalid_r <= 1'b0; stop_r <= 1'b0;
      stamp_r <= '0; lease_r <= '0; rvalid_r <= '0; svalid_r <= '0;
      pv_r <= 1'b0; idx_r <= '0;
    end else begin
      if (ovalid_r && out_tready && st_r != S_DONE) ovalid_r <= 1'b0;
      pidx_r <= idx_r;
      unique case (st_r)
        S_IDLE: if (in_tvalid && in_tready) begin
          cmd_r <= cmd_t'(in_tdata[189:0]);
          status_r <= mat_pkg::StDone; grant_r <= '0; evict_r <= '0;
          rhit_r <= '1; rfree_r <= '1; shit_r <= '1; sfree_r <= '1;
          idx_r <= '0; pv_r <= 1'b0; cnt_r <= '0; newrec_r <= 1'b0;
          st_r <= S_SSCAN;
        end
        S_SSCAN: begin
          // slot table walk: dedup match and first free slot
          if (pv_r) begin
            if (smatch && shit_r[SW]) shit_r <= {1'b0, psx};
            if (!svalid_r[psx] && sfree_r[SW]) sfree_r <= {1'b0, psx};
          end
          if (idx_r == CW'(mat_pkg::SlotEntries)) begin
            idx_r <= '0; pv_r <= 1'b0; st_r <= S_RSCAN;
          end else begin
            idx_r <= idx_r + 1'b1; pv_r <= 1'b1;
          end
        end
        S_RSCAN: begin
          // record walk: key match, first free entry, count
          if (pv_r) begin
            if (rvalid_r[prx]) cnt_r <= cnt_r + 1'b1;
            if (rvalid_r[prx] && rrd_r.key == cmd_r.key && rhit_r[RW])
              rhit_r <= {1'b0, prx};
            if (!rvalid_r[prx] && rfree_r[RW]) rfree_r <= {1'b0, prx};
          end
          if (idx_r == CW'(mat_pkg::RecEntries)) begin
            idx_r <= '0; pv_r <= 1'b0; st_r <= S_EVAL;
          end else begin
            idx_r <= idx_r + 1'b1; pv_r <= 1'b1;
          end
        end
        S_EVAL: st_r <= S_RDRES;  // record, slot, residency reads in flight
        S_RDRES: begin
          unique case (cmd_r.cmd)
            mat_pkg::CmdAcquire: begin
              status_r <= acq_st;
              if (acq_st == mat_pkg::StGranted) begin
                grant_r <= lease_r + 32'd1;
                if (rhit_r[RW]) begin rhit_r <= rfree_r; newrec_r <= 1'b1; end
                st_r <= S_WRITE;
              end else st_r <= S_DONE;
            end
            mat_pkg::CmdRelease: begin
              if (shit_r[SW] || srd_r.lease != cmd_r.lease) begin
                status_r <= mat_pkg::StNoOwnSlot; best_r <= '1; st_r <= S_TSCAN;
              end else st_r <= S_WRITE;
            end
            mat_pkg::CmdCommit: begin
              if (rhit_r[RW] && rfree_r[RW]) begin
                status_r <= mat_pkg::StTableFull; st_r <= S_DONE;
              end else begin
                if (rhit_r[RW]) begin rhit_r <= rfree_r; newrec_r <= 1'b1; end
                st_r <= S_WRITE;
              end
            end
            mat_pkg::CmdDelete: begin
              if (!rhit_r[RW]) rvalid_r[rh] <= 1'b0;
              st_r <= S_DONE;
            end
            mat_pkg::CmdStop: begin
              stop_r <= 1'b1; st_r <= S_DONE;
            end
            default: begin
              status_r <= mat_pkg::StInvalid; st_r <= S_DONE;
            end
          endcase
        end
        S_WRITE: begin
          if (newrec_r) begin
            rvalid_r[rh] <= 1'b1; cnt_r <= cnt_r + 1'b1;
          end
          unique case (cmd_r.cmd)
            mat_pkg::CmdAcquire: begin
              stamp_r <= stamp_r + (newrec_r ? 32'd2 : 32'd1);
              lease_r <= lease_r + 32'd1;
              svalid_r[sfree_r[SW-1:0]] <= 1'b1;
            end
            mat_pkg::CmdRelease: begin
              svalid_r[shit_r[SW-1:0]] <= 1'b0;
              if (rwe) stamp_r <= stamp_r + 32'd1;
            end
            default: begin
              stamp_r <= stamp_r + (newrec_r ? 32'd2 : 32'd1);
            end
          endcase
          idx_r <= '0; pv_r <= 1'b0; best_r <= '1; st_r <= S_TSCAN;
        end
        S_TSCAN: begin
          // trimming: one oldest-unpinned search per eviction
          if ({1'b0, cnt_r} <= {1'b0, limit}) st_r <= S_DONE;
          else if (idx_r == CW'(mat_pkg::RecEntries)) begin
            // last entry may be the winner this cycle
            idx_r <= '0; pv_r <= 1'b0; best_r <= '1;
            if (best_r[RW] && !cand) st_r <= S_DONE;
            else begin
              if (cand) rvalid_r[prx] <= 1'b0;
              else rvalid_r[best_r[RW-1:0]] <= 1'b0;
              cnt_r <= cnt_r - 1'b1; evict_r <= evict_r + 7'd1;
            end
          end else begin
            if (cand) begin
              best_r <= {1'b0, prx}; btouch_r <= rrd_r.touch;
            end
            idx_r <= idx_r + 1'b1; pv_r <= 1'b1;
          end
        end
        S_DONE: if (!ovalid_r || out_tready) begin
          ovalid_r <= 1'b1;
          odata_r <= {5'd0, evict_r, grant_r, status_r};
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // a result is produced only when a command has run
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(st_r) == S_DONE) else $error("spurious result");
  // a held result stays unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata)) else $error("result changed");
  // no command is taken during a walk
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    st_r != S_IDLE |-> !in_tready) else $error("ready while busy");
`endif
endmodule
`default_nettype wire
